>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in rst
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/pme_pkg.sv
// ----------------------------------------------------------------------------
// pme_pkg
// types and constants of the peak meter envelope block
// ----------------------------------------------------------------------------
package pme_pkg;

  localparam int CH_W     = 3;
  localparam int CH_SLOTS = 8;
  localparam int SMP_W    = 24;
  localparam int ENV_W    = 23;
  localparam int COEF_W   = 16;
  localparam int PROD_W   = ENV_W + COEF_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 23;
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = 2;
  localparam int QCNT_W   = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR   = 2'd2;

  localparam logic [COEF_W-1:0] ATTACK_RST  = 16'd6554;
  localparam logic [COEF_W-1:0] RELEASE_RST = 16'd66;
  localparam logic [ENV_W-1:0]  FLOOR_RST   = 23'd84;
  localparam logic [ENV_W-1:0]  MAG_MAX     = 23'h7FFFFF;

  typedef struct packed {
    logic [COEF_W-1:0] attack;
    logic [COEF_W-1:0] rel;
    logic [ENV_W-1:0]  floor;
  } cfg_t;

  typedef struct packed {
    logic [CH_W-1:0]  ch;
    logic             ch_ok;
    logic [ENV_W-1:0] mag;
    logic             last;
  } item_t;

endpackage

>>> rtl/pme_if.sv
// ----------------------------------------------------------------------------
// pme interfaces
// valid/ready channels for sample beats and result beats
// ----------------------------------------------------------------------------
interface pme_sample_if;
  logic                      valid;
  logic                      ready;
  logic [pme_pkg::CH_W-1:0]  channel;
  logic signed [pme_pkg::SMP_W-1:0] sample;
  logic                      block_end;

  modport source (output valid, output channel, output sample, output block_end,
                  input ready);
  modport sink   (input valid, input channel, input sample, input block_end,
                  output ready);
endinterface

interface pme_result_if;
  logic                      valid;
  logic                      ready;
  logic [pme_pkg::CH_W-1:0]  channel_out;
  logic [pme_pkg::ENV_W-1:0] envelope;
  logic                      peak_valid;
  logic [pme_pkg::ENV_W-1:0] block_peak;

  modport source (output valid, output channel_out, output envelope,
                  output peak_valid, output block_peak, input ready);
  modport sink   (input valid, input channel_out, input envelope,
                  input peak_valid, input block_peak, output ready);
endinterface

>>> rtl/pme_front.sv
// ----------------------------------------------------------------------------
// pme_front
// takes sample beats, finds magnitude and channel range, queues them
// ----------------------------------------------------------------------------
module pme_front #(
  parameter int CHANNELS = 8
) (
  input  logic           clk,
  input  logic           rst,
  pme_sample_if.sink     samples,
  output logic           q_valid,
  output pme_pkg::item_t q_item,
  input  logic           q_pop
);

  localparam logic [6:0] CH_LIMIT = 7'(CHANNELS);

  pme_pkg::item_t                   q [pme_pkg::QDEPTH];
  logic [pme_pkg::QPTR_W-1:0]       head;
  logic [pme_pkg::QPTR_W-1:0]       tail;
  logic [pme_pkg::QCNT_W-1:0]       count;
  logic                             push;
  logic                             pop;
  pme_pkg::item_t                   item_in;
  logic [pme_pkg::SMP_W-1:0]        neg;

  always_comb begin
    neg = -samples.sample;
    item_in.ch    = samples.channel;
    item_in.ch_ok = {4'b0, samples.channel} < CH_LIMIT;
    item_in.last  = samples.block_end;
    if (!samples.sample[pme_pkg::SMP_W-1]) begin
      item_in.mag = samples.sample[pme_pkg::ENV_W-1:0];
    end else if (neg[pme_pkg::SMP_W-1]) begin
      item_in.mag = pme_pkg::MAG_MAX;
    end else begin
      item_in.mag = neg[pme_pkg::ENV_W-1:0];
    end
  end

  assign samples.ready = count != pme_pkg::QCNT_W'(pme_pkg::QDEPTH);
  assign push    = samples.valid && samples.ready;
  assign q_valid = count != '0;
  assign pop     = q_pop && q_valid;
  assign q_item  = q[head];

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= tail + 1'b1;
      end
      if (pop) begin
        head <= head + 1'b1;
      end
      count <= count + pme_pkg::QCNT_W'(push) - pme_pkg::QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[tail] <= item_in;
    end
  end

endmodule

>>> rtl/pme_back.sv
// ----------------------------------------------------------------------------
// pme_back
// per-channel attack/release update, block maximum and result register
// ----------------------------------------------------------------------------
module pme_back #(
  parameter int CHANNELS = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  pme_pkg::cfg_t  cfg,
  input  logic           q_valid,
  input  pme_pkg::item_t q_item,
  output logic           q_pop,
  pme_result_if.source   results
);

  localparam int DEPTH = (CHANNELS < pme_pkg::CH_SLOTS) ? CHANNELS : pme_pkg::CH_SLOTS;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [pme_pkg::ENV_W-1:0]  env_store [DEPTH];
  logic [pme_pkg::ENV_W-1:0]  max_store [DEPTH];
  logic [IDX_W-1:0]           idx;
  logic [pme_pkg::ENV_W-1:0]  env_cur;
  logic [pme_pkg::ENV_W-1:0]  max_cur;
  logic                       decay;
  logic [pme_pkg::ENV_W-1:0]  operand;
  logic [pme_pkg::COEF_W-1:0] coeff;
  logic [pme_pkg::PROD_W-1:0] prod;
  logic [pme_pkg::ENV_W-1:0]  step;
  logic [pme_pkg::ENV_W-1:0]  env_next;
  logic [pme_pkg::ENV_W-1:0]  max_next;
  logic [pme_pkg::ENV_W-1:0]  peak;
  logic                       take;
  logic                       update;
  logic                       out_valid;

  always_comb begin
    idx     = q_item.ch[IDX_W-1:0];
    env_cur = env_store[idx];
    max_cur = max_store[idx];
    decay   = q_item.mag < env_cur;
    operand = decay ? env_cur : q_item.mag - env_cur;
    coeff   = decay ? cfg.rel : cfg.attack;
    prod    = {{pme_pkg::ENV_W{1'b0}}, coeff} * {{pme_pkg::COEF_W{1'b0}}, operand};
    step    = prod[pme_pkg::PROD_W-1:pme_pkg::COEF_W];
    env_next = decay ? env_cur - step : env_cur + step;
    max_next = (env_next > max_cur) ? env_next : max_cur;
    peak     = (max_next < cfg.floor) ? cfg.floor : max_next;
  end

  assign take   = !out_valid || results.ready;
  assign q_pop  = take;
  assign update = take && q_valid && q_item.ch_ok;
  assign results.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
        env_store[i] <= '0;
        max_store[i] <= '0;
      end
    end else begin
      if (take) begin
        out_valid <= q_valid;
      end
      if (update) begin
        env_store[idx] <= env_next;
        max_store[idx] <= q_item.last ? '0 : max_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && q_valid) begin
      results.channel_out <= q_item.ch;
      results.envelope    <= q_item.ch_ok ? env_next : '0;
      results.peak_valid  <= q_item.ch_ok && q_item.last;
      results.block_peak  <= (q_item.ch_ok && q_item.last) ? peak : '0;
    end
  end

endmodule

>>> rtl/peak_meter_envelope.sv
// ----------------------------------------------------------------------------
// peak_meter_envelope
// multichannel peak program meter with attack/release envelope per channel
// ----------------------------------------------------------------------------
//   port      dir  beat contents
//   samples   in   channel, sample, block_end
//   results   out  channel_out, envelope, peak_valid, block_peak
//   cfg_*     in   register write: cfg_we, cfg_index, cfg_data
//
// one sample per clock sustained while results are ready; a sample is written
// into the queue and then, with its envelope, into the result register; the
// envelope update (one 16x23 multiply and add or subtract) is combinational
// a four-entry queue absorbs up to four samples while results stall
// rst is synchronous: coefficients to defaults, envelopes and maxima to zero
// ----------------------------------------------------------------------------
module peak_meter_envelope #(
  parameter int CHANNELS = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  pme_sample_if.sink                        samples,
  pme_result_if.source                      results,
  input  logic                              cfg_we,
  input  logic [pme_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pme_pkg::CFG_DATA_W-1:0]    cfg_data
);

  pme_pkg::cfg_t  cfg;
  logic           q_valid;
  pme_pkg::item_t q_item;
  logic           q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.attack <= pme_pkg::ATTACK_RST;
      cfg.rel    <= pme_pkg::RELEASE_RST;
      cfg.floor  <= pme_pkg::FLOOR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        pme_pkg::CFG_ATTACK:  cfg.attack <= cfg_data[pme_pkg::COEF_W-1:0];
        pme_pkg::CFG_RELEASE: cfg.rel    <= cfg_data[pme_pkg::COEF_W-1:0];
        pme_pkg::CFG_FLOOR:   cfg.floor  <= cfg_data[pme_pkg::ENV_W-1:0];
        default: ;
      endcase
    end
  end

  pme_front #(.CHANNELS(CHANNELS)) u_front (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  pme_back #(.CHANNELS(CHANNELS)) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .results (results)
  );

endmodule

>>> rtl/pme_checker.sv
// ----------------------------------------------------------------------------
// pme_checker
// port-level checks on the peak meter envelope block
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pme_checker #(
  parameter int CHANNELS = 8
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [pme_pkg::CH_W-1:0]   channel_out,
  input logic [pme_pkg::ENV_W-1:0]  envelope,
  input logic                       peak_valid,
  input logic [pme_pkg::ENV_W-1:0]  block_peak
);

  localparam logic [6:0] CH_LIMIT = 7'(CHANNELS);

  logic       in_acc;
  logic       out_acc;
  logic [3:0] pending;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 4'(in_acc) - 4'(out_acc);
    end
  end

  // every result beat belongs to an earlier sample beat
  `ASSERT_IMP(a_no_phantom, out_acc, pending != 4'd0)
  // queue plus result register bound what is in flight
  `ASSERT_IMP(a_in_flight, 1'b1, pending <= 4'd5)
  `ASSERT_IMP(a_peak_zero, out_valid && !peak_valid, block_peak == '0)
  `ASSERT_IMP(a_bad_channel, out_valid && ({4'b0, channel_out} >= CH_LIMIT),
              envelope == '0 && !peak_valid)
  `ASSERT_NXT(a_hold, out_valid && !out_ready,
              out_valid && $stable(envelope) && $stable(channel_out))

endmodule

bind peak_meter_envelope pme_checker #(.CHANNELS(CHANNELS)) u_pme_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (samples.valid),
  .in_ready    (samples.ready),
  .out_valid   (results.valid),
  .out_ready   (results.ready),
  .channel_out (results.channel_out),
  .envelope    (results.envelope),
  .peak_valid  (results.peak_valid),
  .block_peak  (results.block_peak)
);
